[design/mt19937_word_generator_top_macros.svh]
// Assertion macros for the MT19937 word generator.
// Used by mt19937_word_generator_top; expects clk and rst_n in scope.
`ifndef MT19937_WORD_GENERATOR_TOP_MACROS_SVH
`define MT19937_WORD_GENERATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define MTWG_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtwg assertion failed");
// Next-cycle implication, checked outside reset.
`define MTWG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtwg assertion failed");
`else
`define MTWG_ASSERT_IMPLY(label, ante, cons)
`define MTWG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/mtwg_pkg.sv]
// Shared types and constants for the MT19937 word generator.
// No dependencies; used by the controller, the datapath and the top level.
package mtwg_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned STATE_WORDS  = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned IDX_W        = $clog2(STATE_WORDS);

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;

    // Operation codes of an input item.
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SEED = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic seed_begin;    // write word 0, load the recurrence registers
        logic use_default;   // seed from the default word, not the input
        logic seed_mul;      // register the recurrence product
        logic seed_add;      // finish one seeded word and write it
        logic draw_update;   // twist the current word and write it back
        logic res_save;      // park the tempered word
        logic out_load;      // load the output register
        logic out_take_res;  // output comes from the parked word
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic seed_last;     // the word being seeded is the last one
    } status_t;

endpackage

[design/mtwg_ram.sv]
// Generic simple dual-read RAM: one write port, two registered read ports.
// No dependencies.
module mtwg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[design/mtwg_ctrl.sv]
// Controller state machine for the MT19937 word generator.
// Depends on mtwg_pkg for the command and status structs and op codes.
module mtwg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    output logic              out_valid,
    input  logic              out_stall,
    input  mtwg_pkg::status_t status,
    output mtwg_pkg::cmd_t    cmd
);
    import mtwg_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SEED_MUL = 6'b000010,
        ST_SEED_ADD = 6'b000100,
        ST_DRAW_RD  = 6'b001000,
        ST_DRAW_WR  = 6'b010000,
        ST_HOLD     = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   seeded_reg, seeded_next;
    logic   pend_reg, pend_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // Next-state and command decode.
    always_comb
    begin
        state_next  = state_reg;
        seeded_next = seeded_reg;
        pend_next   = pend_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_SEED)
                    begin
                        cmd.seed_begin = 1'b1;
                        pend_next      = 1'b0;
                        state_next     = ST_SEED_MUL;
                    end
                    else if (!seeded_reg)
                    begin
                        // A draw before any seed seeds with the default word first.
                        cmd.seed_begin  = 1'b1;
                        cmd.use_default = 1'b1;
                        pend_next       = 1'b1;
                        state_next      = ST_SEED_MUL;
                    end
                    else
                    begin
                        // Table reads are issued this cycle from the current index.
                        state_next = ST_DRAW_WR;
                    end
                end
            end
            ST_SEED_MUL:
            begin
                cmd.seed_mul = 1'b1;
                state_next   = ST_SEED_ADD;
            end
            ST_SEED_ADD:
            begin
                cmd.seed_add = 1'b1;
                if (status.seed_last)
                begin
                    seeded_next = 1'b1;
                    state_next  = pend_reg ? ST_DRAW_RD : ST_HOLD;
                end
                else
                begin
                    state_next = ST_SEED_MUL;
                end
            end
            ST_DRAW_RD:
            begin
                state_next = ST_DRAW_WR;
            end
            ST_DRAW_WR:
            begin
                cmd.draw_update = 1'b1;
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.res_save = 1'b1;
                    state_next   = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_take_res = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag follows loads and completed output handshakes.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seeded_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[design/mtwg_datapath.sv]
// Datapath for the MT19937 word generator: seeding recurrence, twist, tempering.
// Depends on mtwg_pkg; drives the write and read ports of the table RAM.
module mtwg_datapath (
    input  logic                                 clk,
    input  mtwg_pkg::cmd_t                       cmd,
    input  logic [mtwg_pkg::WORD_W-1:0]          seed_value,
    output mtwg_pkg::status_t                    status,
    output logic                                 ram_we,
    output logic [mtwg_pkg::IDX_W-1:0]           ram_waddr,
    output logic [mtwg_pkg::WORD_W-1:0]          ram_wdata,
    output logic [mtwg_pkg::IDX_W-1:0]           ram_raddr_next,
    output logic [mtwg_pkg::IDX_W-1:0]           ram_raddr_far,
    input  logic [mtwg_pkg::WORD_W-1:0]          ram_rdata_next,
    input  logic [mtwg_pkg::WORD_W-1:0]          ram_rdata_far,
    output logic [mtwg_pkg::WORD_W-1:0]          random_word
);
    import mtwg_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] FAR_WRAP  = IDX_W'(STATE_WORDS - TWIST_OFFSET);
    localparam logic [IDX_W-1:0] FAR_STEP  = IDX_W'(TWIST_OFFSET);

    logic [WORD_W-1:0] prev_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] cache_reg;
    logic [WORD_W-1:0] res_reg;
    logic [WORD_W-1:0] word_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [WORD_W-1:0] seed_src;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] prod_next;
    logic [WORD_W-1:0] seed_word;
    logic [WORD_W-1:0] joined;
    logic [WORD_W-1:0] twisted;
    logic [WORD_W-1:0] tempered;
    logic [IDX_W-1:0]  idx_next;

    // Tempering: shifts and masks only.
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] t;
        t = v ^ (v >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    // Seeding recurrence: the product is registered, and the position is added in the next.
    assign seed_src  = cmd.use_default ? DEFAULT_SEED : seed_value;
    assign mix       = prev_reg ^ (prev_reg >> 30);
    assign prod_next = SEED_MULT * mix;
    assign seed_word = prod_reg + WORD_W'(pos_reg);

    // Table addresses of the following word and of the far word.
    assign idx_next       = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign ram_raddr_next = idx_next;
    assign ram_raddr_far  = (idx_reg >= FAR_WRAP) ? idx_reg - FAR_WRAP : idx_reg + FAR_STEP;

    // Twist of the current word; the current word itself is held in cache_reg.
    assign joined   = {cache_reg[WORD_W-1], ram_rdata_next[WORD_W-2:0]};
    assign twisted  = ram_rdata_far ^ (joined >> 1) ^ (joined[0] ? TWIST_MATRIX : '0);
    assign tempered = temper(twisted);

    // Table write port selection.
    always_comb
    begin
        ram_we    = cmd.seed_begin || cmd.seed_add || cmd.draw_update;
        ram_waddr = idx_reg;
        ram_wdata = twisted;
        if (cmd.seed_begin)
        begin
            ram_waddr = '0;
            ram_wdata = seed_src;
        end
        else if (cmd.seed_add)
        begin
            ram_waddr = pos_reg;
            ram_wdata = seed_word;
        end
    end

    assign status.seed_last = (pos_reg == LAST_IDX);
    assign random_word      = word_reg;

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (cmd.seed_begin)
        begin
            prev_reg  <= seed_src;
            cache_reg <= seed_src;
            res_reg   <= seed_src;
            pos_reg   <= IDX_W'(1);
            idx_reg   <= '0;
        end
        if (cmd.seed_mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.seed_add)
        begin
            prev_reg <= seed_word;
            pos_reg  <= pos_reg + 1'b1;
        end
        if (cmd.draw_update)
        begin
            cache_reg <= ram_rdata_next;
            idx_reg   <= idx_next;
        end
        if (cmd.res_save)
        begin
            res_reg <= tempered;
        end
        if (cmd.out_load)
        begin
            word_reg <= cmd.out_take_res ? res_reg : tempered;
        end
    end

endmodule

[design/mt19937_word_generator_top.sv]
// Draw: the result is registered in ST_DRAW_WR, or parked and loaded from ST_HOLD when
// the output stalls; no new item is taken until then. The following and far words are
// read from the table RAM, then the twisted word is written back. Seed: each table word
// passes the multiplier stage and the add, then the echo. A first draw with no seed
// seeds with the default word first. Reset clears the control state and marks the
// generator unseeded; the table is not cleared.
`include "mt19937_word_generator_top_macros.svh"
module mt19937_word_generator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic [mtwg_pkg::WORD_W-1:0] seed_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mtwg_pkg::WORD_W-1:0] random_word
);
    import mtwg_pkg::*;

    cmd_t              cmd;
    status_t           status;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr_next;
    logic [IDX_W-1:0]  ram_raddr_far;
    logic [WORD_W-1:0] ram_rdata_next;
    logic [WORD_W-1:0] ram_rdata_far;

    // Sequencing.
    mtwg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and output register.
    mtwg_datapath u_datapath (
        .clk            (clk),
        .cmd            (cmd),
        .seed_value     (seed_value),
        .status         (status),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr_next (ram_raddr_next),
        .ram_raddr_far  (ram_raddr_far),
        .ram_rdata_next (ram_rdata_next),
        .ram_rdata_far  (ram_rdata_far),
        .random_word    (random_word)
    );

    // State table.
    mtwg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_next),
        .raddr_b (ram_raddr_far),
        .rdata_a (ram_rdata_next),
        .rdata_b (ram_rdata_far)
    );

    // A waiting result is never overwritten.
    `MTWG_ASSERT_IMPLY(a_no_overwrite, cmd.out_load, !out_valid || !out_stall)
    // Each seeded word is preceded by its multiplier cycle.
    `MTWG_ASSERT_IMPLY(a_seed_order, cmd.seed_add, $past(cmd.seed_mul))
    // A seed request keeps the block busy in the following cycle.
    `MTWG_ASSERT_NEXT(a_seed_busy, in_valid && !in_stall && (operation == OP_SEED), in_stall)

endmodule

[tb/mt19937_word_checker.sv]
// Scoreboard for the MT19937 word generator: watches both channels, predicts each result.
// Depends on mtwg_pkg for widths, constants and operation codes.
`timescale 1ns / 100ps
module mt19937_word_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        operation,
    input  logic [mtwg_pkg::WORD_W-1:0] seed_value,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [mtwg_pkg::WORD_W-1:0] random_word,
    output int                          mismatches,
    output int                          outstanding
);
    import mtwg_pkg::*;

    localparam logic [WORD_W-1:0] KEEP_TOP_BIT  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] KEEP_LOW_BITS = 32'h7FFF_FFFF;
    // Index value that marks a generator that has never been seeded.
    localparam logic [9:0]        UNSEEDED      = 10'(STATE_WORDS + 1);

    // Our own copy of the generator state.
    logic [WORD_W-1:0] mt_words [0:STATE_WORDS-1];
    logic [9:0]        mt_index = UNSEEDED;

    // Words still owed by the block, oldest first.
    logic [WORD_W-1:0] expected_words [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Fill the whole state from one seed word with the multiplier recurrence.
    function automatic void seed_words(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] prev;
        mt_words[0] = seed;
        for (int pos = 1; pos < STATE_WORDS; pos++)
        begin
            prev          = mt_words[pos-1];
            mt_words[pos] = SEED_MULT * (prev ^ (prev >> 30)) + 32'(pos);
        end
        mt_index = 10'(STATE_WORDS);
    endfunction

    // Regenerate the full state in place once every word has been used.
    function automatic void twist_words();
        int                nxt;
        int                far_pos;
        logic [WORD_W-1:0] joined;
        logic [WORD_W-1:0] mixed;
        for (int pos = 0; pos < STATE_WORDS; pos++)
        begin
            nxt     = (pos + 1) % STATE_WORDS;
            far_pos = (pos + TWIST_OFFSET) % STATE_WORDS;
            joined  = (mt_words[pos] & KEEP_TOP_BIT) | (mt_words[nxt] & KEEP_LOW_BITS);
            mixed   = mt_words[far_pos] ^ (joined >> 1);
            if (joined[0])
                mixed = mixed ^ TWIST_MATRIX;
            mt_words[pos] = mixed;
        end
        mt_index = '0;
    endfunction

    function automatic logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] raw);
        logic [WORD_W-1:0] v;
        v = raw;
        v = v ^ (v >> 11);
        v = v ^ ((v << 7) & TEMPER_B);
        v = v ^ ((v << 15) & TEMPER_C);
        v = v ^ (v >> 18);
        return v;
    endfunction

    // Advance the generator by one item and return the word it should produce.
    function automatic logic [WORD_W-1:0] next_word(input logic op,
                                                   input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] raw;
        if (op == OP_SEED)
        begin
            seed_words(seed);
            return seed;
        end
        // A draw on an unseeded generator falls back to the default seed.
        if (mt_index >= STATE_WORDS)
        begin
            if (mt_index != STATE_WORDS)
                seed_words(DEFAULT_SEED);
            twist_words();
        end
        raw      = mt_words[mt_index];
        mt_index = mt_index + 10'd1;
        return temper_word(raw);
    endfunction

    // Results are checked before the same edge's item is predicted, so a result
    // can never be matched against an item accepted at that very edge.
    always @(posedge clk or negedge rst_n)
    begin
        logic [WORD_W-1:0] want;
        if (!rst_n)
        begin
            expected_words.delete();
            mt_index    = UNSEEDED;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h",
                             $realtime, random_word);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (random_word !== want)
                    begin
                        $display("%0t: random_word mismatch, expected %h, got %h",
                                 $realtime, want, random_word);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_words.push_back(next_word(operation, seed_value));
            outstanding = expected_words.size();
        end
    end

endmodule

[tb/mt19937_word_generator_top_test.sv]
// Stimulus and verdict for the MT19937 word generator; drives seeds and draws with idling.
// Depends on mtwg_pkg, mt19937_word_generator_top and mt19937_word_checker.
`timescale 1ns / 100ps
module mt19937_word_generator_top_test;
    import mtwg_pkg::*;

    localparam int ITEMS_TOTAL = 1950;
    localparam int LONG_HOLD   = 300;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              operation;
    logic [WORD_W-1:0] seed_value;
    logic              out_valid;
    logic              out_stall;
    logic [WORD_W-1:0] random_word;

    int mismatches;
    int outstanding;
    int items_sent;
    int hold_requests;
    int holds_done;
    bit gap_free;

    mt19937_word_generator_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .seed_value  (seed_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word)
    );

    mt19937_word_checker word_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .seed_value  (seed_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    // Safety net in case the block hangs.
    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Sender idle length: mostly back to back or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gap_free || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Seed words lean toward the edges of the range.
    function automatic logic [WORD_W-1:0] pick_seed();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return WORD_W'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    // Offer one item at a falling edge and hold it until it is taken.
    task automatic offer_item(input logic op, input logic [WORD_W-1:0] seed);
        int gap;
        operation  <= op;
        seed_value <= seed;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // A run of draws with an occasional stray reseed mixed in.
    task automatic draw_run(input int count);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 149) == 0)
                offer_item(OP_SEED, pick_seed());
            else
                offer_item(OP_DRAW, $urandom());
        end
    endtask

    // Stop offering until every accepted item has produced its result.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    // Receiver: random stalls, quiet stretches, and a long hold-off on request.
    initial
    begin
        int stall_left;
        int free_left;
        int r;
        out_stall  = 1'b0;
        holds_done = 0;
        stall_left = 0;
        free_left  = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                stall_left = LONG_HOLD;
                free_left  = 0;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (free_left > 0)
            begin
                out_stall <= 1'b0;
                free_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    free_left = $urandom_range(100, 400);
                else
                    free_left = $urandom_range(0, 4);
                r = $urandom_range(0, 99);
                if (r < 55)
                    stall_left = 0;
                else if (r < 93)
                    stall_left = $urandom_range(1, 3);
                else
                    stall_left = $urandom_range(10, 40);
                out_stall <= 1'b0;
            end
        end
    end

    // Main stimulus and verdict.
    initial
    begin
        int block;
        int run;
        in_valid      = 1'b0;
        operation     = OP_DRAW;
        seed_value    = '0;
        rst_n         = 1'b0;
        gap_free      = 1'b0;
        hold_requests = 0;
        items_sent    = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Draws with no seed must fall back to the default seed.
        offer_item(OP_DRAW, '1);
        offer_item(OP_DRAW, '0);
        // Seed extremes, each followed by draws.
        offer_item(OP_SEED, '0);
        offer_item(OP_DRAW, $urandom());
        offer_item(OP_DRAW, $urandom());
        offer_item(OP_SEED, '1);
        offer_item(OP_DRAW, '0);
        // Reseeding with the default word must restart the default sequence.
        offer_item(OP_SEED, DEFAULT_SEED);
        offer_item(OP_DRAW, $urandom());
        offer_item(OP_DRAW, $urandom());
        offer_item(OP_SEED, 32'h8000_0000);
        offer_item(OP_DRAW, $urandom());
        offer_item(OP_SEED, 32'h7FFF_FFFF);
        offer_item(OP_DRAW, '1);
        // Back-to-back seeds: only the second one counts.
        offer_item(OP_SEED, 32'h5A5A_5A5A);
        offer_item(OP_SEED, 32'hA5A5_A5A5);
        offer_item(OP_DRAW, $urandom());
        offer_item(OP_SEED, 32'd1);
        offer_item(OP_DRAW, $urandom());

        // Random blocks: a seed now and then, followed by a run of draws. Long runs
        // cross the point where the state is regenerated. Only the first block and
        // those from the drain block on may be long, so the hold-off always happens.
        block = 0;
        while (items_sent < ITEMS_TOTAL)
        begin
            gap_free = ($urandom_range(0, 4) == 0);
            if (block == 2)
            begin
                // Hold the output off while items keep coming, to back the block up.
                hold_requests++;
                gap_free = 1'b1;
            end
            if (block == 3 || $urandom_range(0, 4) == 0)
                wait_drained();
            if (block != 2 && $urandom_range(0, 2) != 0)
                offer_item(OP_SEED, pick_seed());
            if (block == 0 || (block > 2 && $urandom_range(0, 11) == 0))
                run = $urandom_range(630, 1300);
            else if (block == 2)
                run = 40;
            else
                run = $urandom_range(1, 50);
            if (run > ITEMS_TOTAL - items_sent)
                run = ITEMS_TOTAL - items_sent;
            draw_run(run);
            block++;
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/mtwg_pkg.sv
design/mtwg_ram.sv
design/mtwg_ctrl.sv
design/mtwg_datapath.sv
design/mt19937_word_generator_top.sv
tb/mt19937_word_checker.sv
tb/mt19937_word_generator_top_test.sv
